// ----- design/auth_packet_frame_checker_macros.svh -----
`ifndef AUTH_PACKET_FRAME_CHECKER_MACROS_SVH
`define AUTH_PACKET_FRAME_CHECKER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define APFC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("apfc assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define APFC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("apfc assertion failed");

`endif

// ----- design/apfc_pkg.sv -----
package apfc_pkg;

   localparam int HEADER_BYTES = 24;
   localparam int COUNT_W      = 17;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 17'h1FFFF;

   // "DAUT" as it appears on the wire, first byte in the low bits.
   localparam logic [31:0] MAGIC_WORD = 32'h5455_4144;

   localparam logic [4:0] OFS_VERSION  = 5'd4;
   localparam logic [4:0] OFS_KIND     = 5'd6;
   localparam logic [4:0] OFS_FLAGS    = 5'd7;
   localparam logic [4:0] OFS_ARGUMENT = 5'd16;
   localparam logic [4:0] OFS_LENGTH   = 5'd20;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 17;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_EXPECTED_VERSION = 2'd0,
      CSR_MAX_PAYLOAD      = 2'd1,
      CSR_MAX_PACKET       = 2'd2,
      CSR_KIND_COUNT       = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [15:0] expected_version;
      logic [15:0] payload_limit;
      logic [16:0] packet_limit;
      logic [8:0]  kind_count;
   } cfg_type;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic        payload_valid;
      logic [7:0]  payload_byte;
      logic        packet_done;
      logic        packet_ok;
      logic [7:0]  packet_kind;
      logic [7:0]  packet_flags;
      logic [63:0] attempt_id;
      logic [31:0] argument_word;
      logic [15:0] payload_length;
   } rsp_type;

endpackage

// ----- design/apfc_stream_if.sv -----
interface apfc_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- design/apfc_csr.sv -----
module apfc_csr
   import apfc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.expected_version <= 16'd1;
         cfg_ff.payload_limit    <= 16'd4096;
         cfg_ff.packet_limit     <= 17'd4120;
         cfg_ff.kind_count       <= 9'd8;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_EXPECTED_VERSION: cfg_ff.expected_version <= csr_wdata[15:0];
            CSR_MAX_PAYLOAD:      cfg_ff.payload_limit    <= csr_wdata[15:0];
            CSR_MAX_PACKET:       cfg_ff.packet_limit     <= csr_wdata[16:0];
            CSR_KIND_COUNT:       cfg_ff.kind_count       <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- design/apfc_frame_parse.sv -----
module apfc_frame_parse
   import apfc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   input  logic    slot_free,
   output logic    res_valid,
   output rsp_type res_data
);

   logic                in_valid_ff;
   req_type             in_data_ff;

   logic [COUNT_W-1:0]  byte_count_ff, byte_count_in;
   logic                header_bad_ff, header_bad_in;
   logic [15:0]         version_ff, version_in;
   logic [7:0]          kind_ff, kind_in;
   logic [7:0]          flags_ff, flags_in;
   logic [63:0]         attempt_ff, attempt_in;
   logic [31:0]         argument_ff, argument_in;
   logic [31:0]         length_ff, length_in;
   logic                nul_seen_ff, nul_seen_in;

   logic                is_payload;
   logic                has_result;
   logic                take;
   logic [4:0]          hpos;
   logic [7:0]          b;
   logic [32:0]         expected_size;
   logic                verdict_ok;
   logic                packet_ok;

   assign b          = in_data_ff.byte_value;
   assign hpos       = byte_count_ff[4:0];
   assign is_payload = byte_count_ff >= COUNT_W'(HEADER_BYTES);
   assign has_result = is_payload || in_data_ff.last_byte;
   assign take       = in_valid_ff && (!has_result || slot_free);
   assign req_ready  = !in_valid_ff || take;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (take) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   always_comb begin
      byte_count_in = byte_count_ff;
      header_bad_in = header_bad_ff;
      version_in    = version_ff;
      kind_in       = kind_ff;
      flags_in      = flags_ff;
      attempt_in    = attempt_ff;
      argument_in   = argument_ff;
      length_in     = length_ff;
      nul_seen_in   = nul_seen_ff;

      if (byte_count_ff != COUNT_MAX) begin
         byte_count_in = byte_count_ff + 1'b1;
      end

      // Header fields start at zero, so each byte lands in its lane directly.
      if (!is_payload) begin
         if (hpos < OFS_VERSION) begin
            if (b != MAGIC_WORD[{hpos[1:0], 3'b000} +: 8]) begin
               header_bad_in = 1'b1;
            end
         end else if (hpos < OFS_KIND) begin
            version_in[{hpos[0], 3'b000} +: 8] = b;
         end else if (hpos == OFS_KIND) begin
            kind_in = b;
         end else if (hpos == OFS_FLAGS) begin
            flags_in = b;
         end else if (hpos < OFS_ARGUMENT) begin
            attempt_in[{hpos[2:0], 3'b000} +: 8] = b;
         end else if (hpos < OFS_LENGTH) begin
            argument_in[{hpos[1:0], 3'b000} +: 8] = b;
         end else begin
            length_in[{hpos[1:0], 3'b000} +: 8] = b;
         end
      end else if (b == 8'd0) begin
         nul_seen_in = 1'b1;
      end
   end

   // The verdict looks at the state as it stands after the last byte.
   assign expected_size = {1'b0, length_in} + 33'(HEADER_BYTES);
   assign verdict_ok = (byte_count_in >= COUNT_W'(HEADER_BYTES))
                    && (byte_count_in <= cfg.packet_limit)
                    && !header_bad_in
                    && (version_in == cfg.expected_version)
                    && ({1'b0, kind_in} < cfg.kind_count)
                    && (length_in <= {16'd0, cfg.payload_limit})
                    && (expected_size == {16'd0, byte_count_in})
                    && !nul_seen_in;
   assign packet_ok = in_data_ff.last_byte && verdict_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         header_bad_ff <= 1'b0;
         version_ff    <= '0;
         kind_ff       <= '0;
         flags_ff      <= '0;
         attempt_ff    <= '0;
         argument_ff   <= '0;
         length_ff     <= '0;
         nul_seen_ff   <= 1'b0;
      end else if (take) begin
         if (in_data_ff.last_byte) begin
            byte_count_ff <= '0;
            header_bad_ff <= 1'b0;
            version_ff    <= '0;
            kind_ff       <= '0;
            flags_ff      <= '0;
            attempt_ff    <= '0;
            argument_ff   <= '0;
            length_ff     <= '0;
            nul_seen_ff   <= 1'b0;
         end else begin
            byte_count_ff <= byte_count_in;
            header_bad_ff <= header_bad_in;
            version_ff    <= version_in;
            kind_ff       <= kind_in;
            flags_ff      <= flags_in;
            attempt_ff    <= attempt_in;
            argument_ff   <= argument_in;
            length_ff     <= length_in;
            nul_seen_ff   <= nul_seen_in;
         end
      end
   end

   assign res_valid = take && has_result;

   always_comb begin
      res_data                = '0;
      res_data.payload_valid  = is_payload;
      res_data.payload_byte   = is_payload ? b : 8'd0;
      res_data.packet_done    = in_data_ff.last_byte;
      res_data.packet_ok      = packet_ok;
      if (packet_ok) begin
         res_data.packet_kind    = kind_in;
         res_data.packet_flags   = flags_in;
         res_data.attempt_id     = attempt_in;
         res_data.argument_word  = argument_in;
         res_data.payload_length = length_in[15:0];
      end
   end

endmodule

// ----- design/apfc_out_reg.sv -----
module apfc_out_reg
   import apfc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    res_valid,
   input  rsp_type res_data,
   output logic    slot_free,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_data_ff <= res_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- design/auth_packet_frame_checker.sv -----
// Authentication packet frame checker.
// The req_if channel carries one packet byte per transaction, with last_byte
// set on the final byte. The first 24 bytes are the header (magic, version,
// kind, flags, attempt id, argument, payload length); later bytes are payload.
// The rsp_if channel carries one transaction per payload byte and one for the
// last byte, which holds the verdict and, when it passed, the header fields.
// Header bytes other than the last byte give no response.
// The csr_ port writes the four limit registers; write only while idle.
// A byte accepted into the input register is checked there, and its response
// is captured in the response register and presented from it.
// Throughput: one byte per cycle unless rsp_ready stalls a byte that needs a
// response; the check between the input and response registers is combinational.
// When rsp_ready is low the response register holds; header bytes keep
// flowing, and a byte that needs a response waits in the input register.
// Synchronous reset empties both registers (their valid flags only), clears
// the packet state and restores the limit registers to their defaults.
module auth_packet_frame_checker
   import apfc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   apfc_stream_if.sink            req_if,
   apfc_stream_if.source          rsp_if,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type cfg;
   req_type req_data;
   rsp_type res_data;
   rsp_type rsp_data;
   logic    res_valid;
   logic    slot_free;
   logic    req_ready;
   logic    rsp_valid;

   assign req_data      = req_if.payload;
   assign req_if.ready  = req_ready;
   assign rsp_if.valid  = rsp_valid;
   assign rsp_if.payload = rsp_data;

   apfc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   apfc_frame_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .slot_free (slot_free),
      .res_valid (res_valid),
      .res_data  (res_data)
   );

   apfc_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res_data  (res_data),
      .slot_free (slot_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_if.ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- design/apfc_checker.sv -----
`include "auth_packet_frame_checker_macros.svh"

module apfc_checker
   import apfc_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);

   logic rsp_stalled;
   logic rsp_ok;
   logic rsp_no_byte;
   logic fields_zero;

   assign rsp_stalled = rsp_valid && !rsp_ready;
   assign rsp_ok      = rsp_valid && rsp_payload.packet_ok;
   assign rsp_no_byte = rsp_valid && !rsp_payload.payload_valid;
   assign fields_zero = (rsp_payload.attempt_id == 64'd0)
                     && (rsp_payload.argument_word == 32'd0)
                     && (rsp_payload.payload_length == 16'd0)
                     && (rsp_payload.packet_kind == 8'd0)
                     && (rsp_payload.packet_flags == 8'd0);

   `APFC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stalled, rsp_valid && $stable(rsp_payload))

   `APFC_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

   `APFC_ASSERT_NOW(a_ok_only_on_done, clock, reset, rsp_ok, rsp_payload.packet_done)

   `APFC_ASSERT_NOW(a_fields_zero_on_fail, clock, reset, rsp_valid && !rsp_ok, fields_zero)

   `APFC_ASSERT_NOW(a_byte_zero_off_payload, clock, reset, rsp_no_byte, !(|rsp_payload.payload_byte))

endmodule

bind auth_packet_frame_checker apfc_checker u_apfc_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_payload (rsp_if.payload)
);
